// ===== hdl/scfc_pkg.sv =====
// Package of shared constants and types for the serial command frame checker.
package scfc_pkg;

  localparam int unsigned HistDepth = 5;

  localparam logic [7:0] HDR_FIRST     = 8'h55;
  localparam logic [7:0] HDR_SECOND    = 8'hAA;
  localparam logic [7:0] STATION_RESET = 8'h1E;

  // One result beat as it leaves the frame logic.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_ok;
    logic [7:0] command_byte;
  } scfc_result_t;

endpackage

// ===== hdl/scfc_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
interface scfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfc_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_index;
  logic       frame_done;
  logic       frame_ok;
  logic [7:0] command_byte;

  modport source (
    output valid, output payload_valid, output payload_index,
    output frame_done, output frame_ok, output command_byte, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_index,
    input frame_done, input frame_ok, input command_byte, output ready
  );
endinterface

interface scfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/scfc_core.sv =====
// Frame tracking state and per-byte decode for the serial command frame checker.
module scfc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            station_address,
  output scfc_pkg::scfc_result_t result
);

  logic [7:0] hist_r [scfc_pkg::HistDepth];
  logic       collecting_r, collecting_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] byte_offset_r, byte_offset_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] held_command_r, held_command_nxt;
  logic       match;

  assign match = (hist_r[4] == scfc_pkg::HDR_FIRST) &&
                 (hist_r[3] == scfc_pkg::HDR_SECOND) &&
                 (hist_r[2] == station_address) &&
                 (hist_r[0] != 8'h00);

  always_comb begin
    collecting_nxt   = collecting_r;
    frame_length_nxt = frame_length_r;
    byte_offset_nxt  = byte_offset_r;
    running_sum_nxt  = running_sum_r;
    held_command_nxt = held_command_r;
    result           = '0;
    if (collecting_r) begin
      if (byte_offset_r == frame_length_r) begin
        result.frame_done    = 1'b1;
        result.frame_ok      = (~running_sum_r == rx_byte);
        result.command_byte  = held_command_r;
        collecting_nxt       = 1'b0;
      end else begin
        result.payload_valid = 1'b1;
        result.payload_index = byte_offset_r;
        running_sum_nxt      = running_sum_r + rx_byte;
        byte_offset_nxt      = byte_offset_r + 8'd1;
      end
    end else if (match) begin
      // The byte after the length is the command, payload position zero.
      collecting_nxt       = 1'b1;
      frame_length_nxt     = hist_r[0];
      held_command_nxt     = rx_byte;
      running_sum_nxt      = rx_byte;
      byte_offset_nxt      = 8'd1;
      result.payload_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r   <= 1'b0;
      frame_length_r <= '0;
      byte_offset_r  <= '0;
      running_sum_r  <= '0;
      held_command_r <= '0;
      for (int k = 0; k < scfc_pkg::HistDepth; k++) begin
        hist_r[k] <= '0;
      end
    end else if (step) begin
      collecting_r   <= collecting_nxt;
      frame_length_r <= frame_length_nxt;
      byte_offset_r  <= byte_offset_nxt;
      running_sum_r  <= running_sum_nxt;
      held_command_r <= held_command_nxt;
      hist_r[0]      <= rx_byte;
      for (int k = 1; k < scfc_pkg::HistDepth; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

endmodule

// ===== hdl/serial_command_frame_checker.sv =====
// Top level of the serial command frame checker: handshakes, register and result stage.
//
// The checker takes one received byte per input beat and returns exactly one
// result beat per byte, so frames of the form 0x55, 0xAA, station address,
// a byte it ignores, length N, N payload bytes and an inverted-sum checksum
// can be followed byte by byte. A byte can be accepted in every cycle and its
// result appears in the output register in the next cycle; the only limit on
// rate is the output register itself, which holds a result until the sink
// takes it, and the input is ready whenever that register is empty or being
// emptied in the same cycle. Each payload beat reports its position, and the
// checksum beat reports whether the sum matched along with the command, the
// first payload byte. A length byte of zero makes the header void. Header
// scanning is suspended while a frame is being collected. The station
// address register resets to 0x1E and should be written only while no beat
// is in flight; configuration writes are always accepted.
module serial_command_frame_checker (
  input  logic      clk,
  input  logic      rst_n,
  scfc_in_if.sink   in_ch,
  scfc_out_if.source out_ch,
  scfc_cfg_if.sink  cfg_ch
);

  logic                   accept;
  logic [7:0]             station_r;
  logic                   out_valid_r;
  scfc_pkg::scfc_result_t result;
  scfc_pkg::scfc_result_t result_r;

  // A new byte may enter when the result register is free or drains now.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= scfc_pkg::STATION_RESET;
    end else if (cfg_ch.valid) begin
      station_r <= cfg_ch.data;
    end
  end

  // All frame state lives in the core and advances once per accepted beat.
  scfc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (accept),
    .rx_byte         (in_ch.rx_byte),
    .station_address (station_r),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The payload register needs no reset; it is only seen with valid high.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_valid = result_r.payload_valid;
  assign out_ch.payload_index = result_r.payload_index;
  assign out_ch.frame_done    = result_r.frame_done;
  assign out_ch.frame_ok      = result_r.frame_ok;
  assign out_ch.command_byte  = result_r.command_byte;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the serial command frame checker: directed table, random frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted beat, on any channel, before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;

  localparam scfc_pkg::scfc_result_t NoResult = '0;

  // One row of the directed table: the byte to send and, where it is obvious,
  // the result typed in by hand. Rows without a typed result use the predictor.
  typedef struct packed {
    logic [7:0]             rx;
    logic                   typed;
    scfc_pkg::scfc_result_t want;
  } stim_row_t;

  localparam int unsigned DirectedCount = 23;

  // The table starts right after reset with the station address at its reset value.
  // It covers idle bytes at both extremes, a good two-byte frame whose checksum
  // is 0xFF, a header with a zero length that must be ignored, and a one-byte
  // frame with a bad checksum that still reports its command.
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    '{8'h00, 1'b1, NoResult},
    '{8'hFF, 1'b1, NoResult},
    '{8'h55, 1'b1, NoResult},
    '{8'hAA, 1'b0, NoResult},
    '{8'h1E, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult},
    '{8'h02, 1'b0, NoResult},
    '{8'hFF, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0, 8'h00}},
    '{8'h01, 1'b1, '{1'b1, 8'd1, 1'b0, 1'b0, 8'h00}},
    '{8'hFF, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b1, 8'hFF}},
    '{8'h55, 1'b0, NoResult},
    '{8'hAA, 1'b0, NoResult},
    '{8'h1E, 1'b0, NoResult},
    '{8'hFF, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult},
    '{8'h7E, 1'b1, NoResult},
    '{8'h55, 1'b0, NoResult},
    '{8'hAA, 1'b0, NoResult},
    '{8'h1E, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult},
    '{8'h01, 1'b0, NoResult},
    '{8'h80, 1'b1, '{1'b1, 8'd0, 1'b0, 1'b0, 8'h00}},
    '{8'h00, 1'b1, '{1'b0, 8'd0, 1'b1, 1'b0, 8'h80}}
  };

  logic clk;
  logic rst_n;

  scfc_in_if  in_ch ();
  scfc_out_if out_ch ();
  scfc_cfg_if cfg_ch ();

  serial_command_frame_checker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the checker's state, advanced once per accepted input beat.
  logic [4:0][7:0] recent_bytes;    // index 0 is the newest byte
  logic            in_frame;
  logic [7:0]      frame_len;
  logic [7:0]      beat_offset;
  logic [7:0]      payload_sum;
  logic [7:0]      held_cmd;
  logic [7:0]      station;

  scfc_pkg::scfc_result_t pending_results [$];
  int unsigned  mismatch_count;
  int unsigned  items_sent;
  int unsigned  quiet_cycles;
  bit           steady_flow;

  function automatic void reset_frame_model();
    recent_bytes = '0;
    in_frame     = 1'b0;
    frame_len    = 8'd0;
    beat_offset  = 8'd0;
    payload_sum  = 8'd0;
    held_cmd     = 8'd0;
    station      = scfc_pkg::STATION_RESET;
  endfunction

  // Works out the result that one received byte causes and updates the shadow state.
  function automatic scfc_pkg::scfc_result_t predict_frame_byte(logic [7:0] b);
    scfc_pkg::scfc_result_t r;
    logic [7:0]   inv_sum;
    r = '0;
    inv_sum = ~payload_sum;
    if (in_frame) begin
      if (beat_offset == frame_len) begin
        // This is the checksum byte; the frame ends whether or not it matches.
        r.frame_done   = 1'b1;
        r.frame_ok     = (inv_sum == b);
        r.command_byte = held_cmd;
        in_frame       = 1'b0;
      end else begin
        r.payload_valid = 1'b1;
        r.payload_index = beat_offset;
        payload_sum     = payload_sum + b;
        beat_offset     = beat_offset + 8'd1;
      end
    end else if (recent_bytes[4] == scfc_pkg::HDR_FIRST &&
                 recent_bytes[3] == scfc_pkg::HDR_SECOND &&
                 recent_bytes[2] == station && recent_bytes[0] != 8'd0) begin
      // A full header sits in the history, so this byte is the command.
      in_frame        = 1'b1;
      frame_len       = recent_bytes[0];
      held_cmd        = b;
      payload_sum     = b;
      beat_offset     = 8'd1;
      r.payload_valid = 1'b1;
    end
    // The history shifts on every byte, payload and checksum included.
    recent_bytes = {recent_bytes[3:0], b};
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then a long stall.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Payload and noise bytes lean toward header bytes and the extremes, so that
  // header patterns show up inside frames and across frame boundaries.
  function automatic logic [7:0] pick_frame_byte();
    case ($urandom_range(0, 9))
      0: return scfc_pkg::HDR_FIRST;
      1: return scfc_pkg::HDR_SECOND;
      2: return station;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one byte and queues the result it must cause. The valid line is only
  // dropped when a gap follows, so it is never lowered and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input scfc_pkg::scfc_result_t typed_want);
    int unsigned  gap;
    scfc_pkg::scfc_result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_frame_byte(b);
    pending_results.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // Sends the first count bytes of a header.
  task automatic send_header(input logic [7:0] addr, input logic [7:0] len,
                             input int unsigned count);
    logic [7:0] hdr [5];
    hdr[0] = scfc_pkg::HDR_FIRST;
    hdr[1] = scfc_pkg::HDR_SECOND;
    hdr[2] = addr;
    hdr[3] = 8'($urandom_range(0, 255));
    hdr[4] = len;
    for (int k = 0; k < count; k++) send_byte(hdr[k], 1'b0, NoResult);
  endtask

  task automatic send_frame(input logic [7:0] len, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] pb;
    send_header(station, len, 5);
    sum = 8'd0;
    for (int k = 0; k < len; k++) begin
      pb  = pick_frame_byte();
      sum = sum + pb;
      send_byte(pb, 1'b0, NoResult);
    end
    if (good_sum) send_byte(~sum, 1'b0, NoResult);
    else send_byte(~sum ^ 8'($urandom_range(1, 255)), 1'b0, NoResult);
  endtask

  // Mostly random frames, some with bad checksums; the rest is broken headers and noise.
  task automatic run_random_phase(input int unsigned quota);
    int unsigned start;
    int unsigned r;
    logic [7:0]  len;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        r = $urandom_range(0, 99);
        if (r < 85) len = 8'($urandom_range(1, 8));
        else if (r < 98) len = 8'($urandom_range(9, 40));
        else len = 8'($urandom_range(41, 255));
        send_frame(len, $urandom_range(0, 99) < 80);
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0: send_header(station, 8'($urandom_range(1, 255)), $urandom_range(1, 4));
          1: send_header(station ^ 8'($urandom_range(1, 255)), 8'($urandom_range(1, 8)), 5);
          default: send_header(station, 8'd0, 5);
        endcase
        send_byte(pick_frame_byte(), 1'b0, NoResult);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(pick_frame_byte(), 1'b0, NoResult);
      end
    end
  endtask

  // Drains the pipeline so that the station register can be rewritten safely.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] addr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= addr;
    do @(posedge clk); while (!cfg_ch.ready);
    station = addr;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input scfc_pkg::scfc_result_t want,
                               input scfc_pkg::scfc_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t %s: expected pv=%0b idx=%0d done=%0b ok=%0b cmd=%02h,",
                " got pv=%0b idx=%0d done=%0b ok=%0b cmd=%02h"},
               $time, what, want.payload_valid, want.payload_index, want.frame_done,
               want.frame_ok, want.command_byte, got.payload_valid, got.payload_index,
               got.frame_done, got.frame_ok, got.command_byte);
  endtask

  // The result side stalls in the same pattern of short and long gaps.
  initial begin : result_pacing
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Every result beat is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_check
    scfc_pkg::scfc_result_t got;
    scfc_pkg::scfc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.payload_valid = out_ch.payload_valid;
      got.payload_index = out_ch.payload_index;
      got.frame_done    = out_ch.frame_done;
      got.frame_ok      = out_ch.frame_ok;
      got.command_byte  = out_ch.command_byte;
      if (pending_results.size() == 0) begin
        note_mismatch("result beat with nothing expected", NoResult, got);
      end else begin
        want = pending_results.pop_front();
        if (got.payload_valid !== want.payload_valid ||
            got.payload_index !== want.payload_index ||
            got.frame_done !== want.frame_done ||
            got.frame_ok !== want.frame_ok ||
            got.command_byte !== want.command_byte)
          note_mismatch("result beat differs", want, got);
      end
    end
  end

  // The watchdog counts cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("serial_command_frame_checker: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'd0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = 8'd0;
    mismatch_count = 0;
    items_sent     = 0;
    steady_flow    = 1'b0;
    reset_frame_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirectedCount; i++)
      send_byte(DirectedRows[i].rx, DirectedRows[i].typed, DirectedRows[i].want);
    finish_phase();

    // Random phases under several station addresses, the extremes first. The
    // all-ones phase opens with a maximum-length frame so that the payload
    // index reaches its top value, 254.
    write_station(8'h00);
    run_random_phase(110);
    finish_phase();

    write_station(8'hFF);
    send_frame(8'd255, 1'b1);
    run_random_phase(110);
    finish_phase();

    // An address equal to the first header byte makes overlapping headers likely.
    write_station(scfc_pkg::HDR_FIRST);
    run_random_phase(110);
    finish_phase();

    // This phase runs with neither side idling.
    write_station(8'($urandom_range(0, 255)));
    steady_flow = 1'b1;
    run_random_phase(110);
    finish_phase();
    steady_flow = 1'b0;

    write_station(scfc_pkg::STATION_RESET);
    run_random_phase(110);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("serial_command_frame_checker: match");
    end else begin
      $display("serial_command_frame_checker: mismatch");
    end
    $finish;
  end

endmodule
